// ----- hdl/iss_pkg.sv -----
// iss_pkg: shared types and codes for the indexed sequence store
// no dependencies
package iss_pkg;

  // index arithmetic width, covers capacity up to 4096 plus pos+len sums
  localparam int IDX_W = 14;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_ERASE  = 3'd2;
  localparam logic [2:0] ACT_ERANGE = 3'd3;
  localparam logic [2:0] ACT_MOVE   = 3'd4;
  localparam logic [2:0] ACT_SET    = 3'd5;
  localparam logic [2:0] ACT_READ   = 3'd6;
  localparam logic [2:0] ACT_QUERY  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             dir_left;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } shift_ctl_t;

endpackage

// ----- hdl/iss_cell.sv -----
// iss_cell: one storage cell of the element chain
// depends on iss_pkg
module iss_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  iss_pkg::shift_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0]  bus,
  input  logic [VALUE_WIDTH-1:0]  left_val,
  input  logic [VALUE_WIDTH-1:0]  right_val,
  output logic [VALUE_WIDTH-1:0]  val
);

  localparam logic [iss_pkg::IDX_W-1:0] MY_IDX = iss_pkg::IDX_W'(INDEX);

  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] val_nxt;
  logic                   in_rng;

  assign in_rng = (MY_IDX >= ctl.lo) && (MY_IDX < ctl.hi);

  always_comb begin
    val_nxt = val_r;
    if (ctl.en && in_rng) begin
      if (ctl.dir_left) begin
        val_nxt = (MY_IDX == ctl.hi - 1'b1) ? bus : right_val;
      end else begin
        val_nxt = (MY_IDX == ctl.lo) ? bus : left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- hdl/indexed_sequence_store_core.sv -----
// indexed_sequence_store_core: position-addressed sequence store, top level
// depends on iss_pkg and iss_cell
//
// usage
//  - input channel in_*: one request per transaction (insert, append, erase,
//    erase range, move range, set, read, range query)
//  - output channel out_*: exactly one result transaction per request
//  - elements live in a chain of CAPACITY cells; each cell takes its own
//    value, a neighbor's value or the broadcast bus value at each clock
//  - processing per request, from accept to out_valid:
//      errors, read, empty erase/move range : straight to the done state
//      insert, append, erase, set            : one shift step, then done
//      erase range, move range of len L      : L shift steps (one shift a step), then done
//      range query over N elements           : N scan steps (one element a cycle), then done
//  - one request at a time: in_ready is low from accept until the result
//    transaction completes
//  - a stalled receiver holds the result in the output registers
//  - reset clears count, state, step counter and out_valid; cell contents are left as is
//    since only entries below count are ever read
module indexed_sequence_store_core #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [8:0]         in_position,
  input  logic [8:0]         in_range_start,
  input  logic [8:0]         in_range_end,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_read_value,
  output logic signed [39:0] out_range_sum,
  output logic signed [31:0] out_range_min,
  output logic signed [31:0] out_range_max,
  output logic [8:0]         out_element_count,
  output logic [1:0]         out_status
);

  localparam int IW = iss_pkg::IDX_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VW = VALUE_WIDTH;
  localparam logic [IW-1:0] CAP = IW'(CAPACITY);

  iss_pkg::state_t      state_r, state_nxt;
  iss_pkg::shift_ctl_t  ctl;

  logic [VW-1:0]  cell_val [CAPACITY];

  logic [IW-1:0]  count_r, count_nxt;
  logic           dir_left_r, dir_left_nxt;
  logic           fixed_r, fixed_nxt;
  logic [IW-1:0]  lo_r, lo_nxt;
  logic [IW-1:0]  hi_r, hi_nxt;
  logic [IW-1:0]  steps_r, steps_nxt;
  logic [VW-1:0]  bus_r, bus_nxt;
  logic [VW-1:0]  bus;

  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    rd_r, rd_nxt;
  logic [39:0]    sum_r, sum_nxt;
  logic [VW-1:0]  mn_r, mn_nxt;
  logic [VW-1:0]  mx_r, mx_nxt;
  logic [1:0]     st_r, st_nxt;
  logic           first_r, first_nxt;
  logic           rd_sel_r, rd_sel_nxt;

  logic [IW-1:0]  pos, rs, re, len;
  logic [VW-1:0]  val_in;
  logic           range_ok;
  logic           accept;
  logic [VW-1:0]  lo_elem, hi_elem;

  assign pos    = IW'(in_position);
  assign rs     = IW'(in_range_start);
  assign re     = IW'(in_range_end);
  assign len    = re - rs;
  assign val_in = VW'(64'(in_item_value));
  assign range_ok = (rs <= re) && (re <= count_r);

  assign in_ready = (state_r == iss_pkg::S_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;

  // element taps for rotation, scan and read
  assign lo_elem = cell_val[lo_r[AW-1:0]];
  assign hi_elem = cell_val[AW'(hi_r - 1'b1)];

  // fixed value for insert/set, otherwise the wrapped end of the rotation
  assign bus = fixed_r ? bus_r : (dir_left_r ? lo_elem : hi_elem);

  assign ctl.en       = (state_r == iss_pkg::S_SHIFT);
  assign ctl.dir_left = dir_left_r;
  assign ctl.lo       = lo_r;
  assign ctl.hi       = hi_r;

  // the cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    iss_cell #(
      .INDEX       (g),
      .VALUE_WIDTH (VW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .bus       (bus),
      .left_val  (cell_val[(g > 0) ? g - 1 : g]),
      .right_val (cell_val[(g < CAPACITY - 1) ? g + 1 : g]),
      .val       (cell_val[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dir_left_nxt  = dir_left_r;
    fixed_nxt     = fixed_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    steps_nxt     = steps_r;
    bus_nxt       = bus_r;
    out_valid_nxt = out_valid_r;
    rd_nxt        = rd_r;
    sum_nxt       = sum_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    st_nxt        = st_r;
    first_nxt     = first_r;
    rd_sel_nxt    = rd_sel_r;

    unique case (state_r)
      iss_pkg::S_IDLE: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
        end
        if (accept) begin
          rd_nxt     = '0;
          sum_nxt    = '0;
          mn_nxt     = '0;
          mx_nxt     = '0;
          st_nxt     = iss_pkg::ST_OK;
          state_nxt  = iss_pkg::S_DONE;
          steps_nxt  = IW'(1);
          fixed_nxt  = 1'b1;
          bus_nxt    = val_in;
          rd_sel_nxt = 1'b0;
          unique case (in_action)
            iss_pkg::ACT_INSERT, iss_pkg::ACT_APPEND: begin
              if (in_action == iss_pkg::ACT_INSERT && pos > count_r) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else if (count_r >= CAP) begin
                st_nxt = iss_pkg::ST_FULL;
              end else begin
                dir_left_nxt = 1'b0;
                lo_nxt       = (in_action == iss_pkg::ACT_INSERT) ? pos : count_r;
                hi_nxt       = count_r + 1'b1;
                count_nxt    = count_r + 1'b1;
                state_nxt    = iss_pkg::S_SHIFT;
              end
            end
            iss_pkg::ACT_ERASE: begin
              if (pos >= count_r) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else begin
                dir_left_nxt = 1'b1;
                fixed_nxt    = 1'b0;
                lo_nxt       = pos;
                hi_nxt       = count_r;
                count_nxt    = count_r - 1'b1;
                state_nxt    = iss_pkg::S_SHIFT;
              end
            end
            iss_pkg::ACT_ERANGE: begin
              if (!range_ok) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else if (len != '0) begin
                dir_left_nxt = 1'b1;
                fixed_nxt    = 1'b0;
                lo_nxt       = rs;
                hi_nxt       = count_r;
                steps_nxt    = len;
                count_nxt    = count_r - len;
                state_nxt    = iss_pkg::S_SHIFT;
              end
            end
            iss_pkg::ACT_MOVE: begin
              if (!range_ok || pos > count_r - len) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else if (len != '0) begin
                // rotate the span between block and destination by len steps
                fixed_nxt = 1'b0;
                steps_nxt = len;
                state_nxt = iss_pkg::S_SHIFT;
                if (pos <= rs) begin
                  dir_left_nxt = 1'b0;
                  lo_nxt       = pos;
                  hi_nxt       = re;
                end else begin
                  dir_left_nxt = 1'b1;
                  lo_nxt       = rs;
                  hi_nxt       = pos + len;
                end
              end
            end
            iss_pkg::ACT_SET: begin
              if (pos >= count_r) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else begin
                dir_left_nxt = 1'b0;
                lo_nxt       = pos;
                hi_nxt       = pos + 1'b1;
                state_nxt    = iss_pkg::S_SHIFT;
              end
            end
            iss_pkg::ACT_READ: begin
              if (pos >= count_r) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else begin
                // element is picked up through the lo tap in the done state
                lo_nxt     = pos;
                rd_sel_nxt = 1'b1;
              end
            end
            iss_pkg::ACT_QUERY: begin
              if (!range_ok) begin
                st_nxt = iss_pkg::ST_INDEX;
              end else if (len == '0) begin
                st_nxt = iss_pkg::ST_EMPTY;
              end else begin
                lo_nxt    = rs;
                hi_nxt    = re;
                first_nxt = 1'b1;
                state_nxt = iss_pkg::S_SCAN;
              end
            end
            default: begin
              st_nxt = iss_pkg::ST_INDEX;
            end
          endcase
        end
      end
      iss_pkg::S_SHIFT: begin
        steps_nxt = steps_r - 1'b1;
        if (steps_r == IW'(1)) begin
          state_nxt = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_SCAN: begin
        // one element a cycle, lo_r walks the range
        sum_nxt   = sum_r + 40'(64'($signed(lo_elem)));
        first_nxt = 1'b0;
        if (first_r || ($signed(lo_elem) < $signed(mn_r))) begin
          mn_nxt = lo_elem;
        end
        if (first_r || ($signed(lo_elem) > $signed(mx_r))) begin
          mx_nxt = lo_elem;
        end
        lo_nxt = lo_r + 1'b1;
        if (lo_r + 1'b1 == hi_r) begin
          state_nxt = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_DONE: begin
        if (rd_sel_r) begin
          rd_nxt = 32'(64'($signed(lo_elem)));
        end
        out_valid_nxt = 1'b1;
        state_nxt     = iss_pkg::S_IDLE;
      end
      default: begin
        state_nxt = iss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iss_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_left_r <= dir_left_nxt;
    fixed_r    <= fixed_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    bus_r      <= bus_nxt;
    rd_r       <= rd_nxt;
    sum_r      <= sum_nxt;
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    st_r       <= st_nxt;
    first_r    <= first_nxt;
    rd_sel_r   <= rd_sel_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = rd_r;
  assign out_range_sum     = sum_r;
  assign out_range_min     = 32'(64'($signed(mn_r)));
  assign out_range_max     = 32'(64'($signed(mx_r)));
  assign out_element_count = count_r[8:0];
  assign out_status        = st_r;

  // count never exceeds the cell chain
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("count above capacity");

  // shifting always has steps left
  a_shift_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == iss_pkg::S_SHIFT |-> steps_r != '0)
    else $error("shift with no steps");

  // count changes only right after a transaction is taken
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count changed without request");

  // a result is raised only at the end of request processing
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == iss_pkg::S_DONE)
    else $error("result without request");

endmodule
